FILE: hdl/pscr_pkg.sv
// pscr_pkg: shared types and constants for the segment crop rewriter
// no dependencies; imported by every module under hdl
package pscr_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_BITS    = 16;
   localparam int REG_W       = 16;
   localparam int CSR_IDX_W   = 2;
   localparam int FO_W        = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int OFS_W       = REG_W + 2;
   localparam int SUM_W       = REG_W + 3;

   localparam logic [BYTE_W-1:0] SEG_PCS = 8'h16;
   localparam logic [BYTE_W-1:0] SEG_WDS = 8'h17;
   localparam int CROP_FLAG_BIT = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_WIDTH  = 2'd0,
      CSR_OUTPUT_HEIGHT = 2'd1,
      CSR_CROP_LEFT     = 2'd2,
      CSR_CROP_TOP      = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0]   data_byte;
      logic                packet_start;
      logic [LEN_BITS-1:0] packet_length;
   } req_data_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              packet_end;
      logic              bounds_error;
   } rsp_data_type;

   typedef struct packed {
      logic [REG_W-1:0] output_width;
      logic [REG_W-1:0] output_height;
      logic [REG_W-1:0] crop_left;
      logic [REG_W-1:0] crop_top;
   } cfg_type;

   typedef enum logic [2:0] {
      OP_PASS = 3'd0,
      OP_HOLD = 3'd1,
      OP_W    = 3'd2,
      OP_H    = 3'd3,
      OP_X    = 3'd4,
      OP_Y    = 3'd5,
      OP_CW   = 3'd6,
      OP_CH   = 3'd7
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [BYTE_W-1:0] lo_byte;
      logic [BYTE_W-1:0] hi_byte;
      logic              flush;
      logic              last;
      logic              clear_err;
   } entry_type;

   typedef enum logic [8:0] {
      PH_TYPE    = 9'b000000001,
      PH_LEN_HI  = 9'b000000010,
      PH_LEN_LO  = 9'b000000100,
      PH_SKIP    = 9'b000001000,
      PH_TAIL    = 9'b000010000,
      PH_PCS     = 9'b000100000,
      PH_PCS_OBJ = 9'b001000000,
      PH_WDS_CNT = 9'b010000000,
      PH_WDS_OBJ = 9'b100000000
   } phase_type;

endpackage

FILE: hdl/pscr_front.sv
// pscr_front: segment parser, classifies each accepted byte into a queue entry
// depends on pscr_pkg
module pscr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  pscr_pkg::req_data_type req_data,
   output logic                  push,
   output pscr_pkg::entry_type   push_entry
);
   import pscr_pkg::*;

   logic [LEN_BITS-1:0] pos_ff, pos_in, len_ff, len_in, seg_ff, seg_in;
   logic [BYTE_W-1:0]   kind_ff, kind_in, obj_ff, obj_in, held_ff, held_in;
   logic [FO_W-1:0]     fo_ff, fo_in;
   logic                crop_ff, crop_in;
   phase_type           phase_ff, phase_in;

   logic [LEN_BITS-1:0] pos_eff, len_eff, seg_eff, size;
   logic [BYTE_W-1:0]   kind_eff, obj_eff, b;
   logic [FO_W-1:0]     fo_eff;
   logic                crop_eff, holding, flush, in_pkt, body;
   phase_type           phase_eff;
   op_type              op;

   always_comb begin
      holding = 1'b0;
      case (phase_ff)
         PH_PCS:     holding = (fo_ff == 5'd1) || (fo_ff == 5'd3);
         PH_PCS_OBJ: holding = (fo_ff >= 5'd5) && fo_ff[0];
         PH_WDS_OBJ: holding = (fo_ff >= 5'd2) && !fo_ff[0];
         default:    holding = 1'b0;
      endcase
   end

   always_comb begin
      b         = req_data.data_byte;
      flush     = 1'b0;
      pos_eff   = pos_ff;
      len_eff   = len_ff;
      seg_eff   = seg_ff;
      kind_eff  = kind_ff;
      obj_eff   = obj_ff;
      fo_eff    = fo_ff;
      crop_eff  = crop_ff;
      phase_eff = phase_ff;
      if (req_data.packet_start) begin
         flush     = (pos_ff < len_ff) && holding;
         len_eff   = (req_data.packet_length == '0) ? LEN_BITS'(1) : req_data.packet_length;
         pos_eff   = '0;
         seg_eff   = '0;
         kind_eff  = '0;
         obj_eff   = '0;
         fo_eff    = '0;
         crop_eff  = 1'b0;
         phase_eff = PH_TYPE;
      end
      in_pkt   = pos_eff < len_eff;
      size     = {held_ff, b};
      op       = OP_PASS;
      body     = 1'b0;
      pos_in   = pos_eff;
      len_in   = len_eff;
      seg_in   = seg_eff;
      kind_in  = kind_eff;
      obj_in   = obj_eff;
      fo_in    = fo_eff;
      crop_in  = crop_eff;
      phase_in = phase_eff;
      held_in  = held_ff;
      if (in_pkt) begin
         pos_in = pos_eff + LEN_BITS'(1);
         unique case (phase_eff)
            PH_TYPE: begin
               if ({1'b0, pos_eff} + (LEN_BITS+1)'(3) > {1'b0, len_eff}) begin
                  phase_in = PH_TAIL;
               end else begin
                  kind_in  = b;
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               held_in  = b;
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if ({2'b0, pos_eff} + (LEN_BITS+2)'(1) + {2'b0, size} > {2'b0, len_eff}) begin
                  phase_in = PH_TAIL;
               end else begin
                  seg_in = size;
                  fo_in  = '0;
                  if (size == '0) begin
                     phase_in = PH_TYPE;
                  end else if (kind_eff == SEG_PCS) begin
                     phase_in = PH_PCS;
                  end else if (kind_eff == SEG_WDS) begin
                     phase_in = PH_WDS_CNT;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_TAIL: begin
               phase_in = PH_TAIL;
            end
            default: body = 1'b1;
         endcase
         if (body) begin
            unique case (phase_eff)
               PH_PCS: begin
                  if (fo_eff == 5'd0 || fo_eff == 5'd2) begin
                     op = (seg_eff >= LEN_BITS'(2)) ? OP_HOLD : OP_PASS;
                  end else if (fo_eff == 5'd1) begin
                     op = OP_W;
                  end else if (fo_eff == 5'd3) begin
                     op = OP_H;
                  end
                  if (fo_eff == 5'd10) begin
                     obj_in   = b;
                     phase_in = PH_PCS_OBJ;
                     fo_in    = '0;
                  end else begin
                     fo_in = fo_eff + FO_W'(1);
                  end
               end
               PH_PCS_OBJ: begin
                  if (fo_eff == 5'd0 && (obj_eff == '0 || seg_eff < LEN_BITS'(8))) begin
                     phase_in = PH_SKIP;
                  end else begin
                     if (fo_eff == 5'd3) begin
                        crop_in = b[CROP_FLAG_BIT] && (seg_eff >= LEN_BITS'(13));
                     end
                     if (fo_eff >= 5'd4 && !fo_eff[0]) begin
                        op = OP_HOLD;
                     end else if (fo_eff == 5'd5 || fo_eff == 5'd9) begin
                        op = OP_X;
                     end else if (fo_eff == 5'd7 || fo_eff == 5'd11) begin
                        op = OP_Y;
                     end else if (fo_eff == 5'd13) begin
                        op = OP_CW;
                     end else if (fo_eff == 5'd15) begin
                        op = OP_CH;
                     end
                     if ((fo_eff == 5'd7 && !crop_eff) || fo_eff == 5'd15) begin
                        obj_in = obj_eff - BYTE_W'(1);
                        fo_in  = '0;
                     end else begin
                        fo_in = fo_eff + FO_W'(1);
                     end
                  end
               end
               PH_WDS_CNT: begin
                  obj_in   = b;
                  phase_in = PH_WDS_OBJ;
                  fo_in    = '0;
               end
               PH_WDS_OBJ: begin
                  if (fo_eff == 5'd0 && (obj_eff == '0 || seg_eff < LEN_BITS'(9))) begin
                     phase_in = PH_SKIP;
                  end else begin
                     if (fo_eff == 5'd1 || fo_eff == 5'd3 || fo_eff == 5'd5 || fo_eff == 5'd7) begin
                        op = OP_HOLD;
                     end else if (fo_eff == 5'd2) begin
                        op = OP_X;
                     end else if (fo_eff == 5'd4) begin
                        op = OP_Y;
                     end else if (fo_eff == 5'd6) begin
                        op = OP_CW;
                     end else if (fo_eff == 5'd8) begin
                        op = OP_CH;
                     end
                     if (fo_eff == 5'd8) begin
                        obj_in = obj_eff - BYTE_W'(1);
                        fo_in  = '0;
                     end else begin
                        fo_in = fo_eff + FO_W'(1);
                     end
                  end
               end
               default: op = OP_PASS;
            endcase
            seg_in = seg_eff - LEN_BITS'(1);
            if (seg_in == '0) begin
               phase_in = PH_TYPE;
               fo_in    = '0;
            end
            if (op == OP_HOLD) begin
               held_in = b;
            end
         end
      end
   end

   assign push                 = accept && (op != OP_HOLD);
   assign push_entry.op        = op;
   assign push_entry.lo_byte   = b;
   assign push_entry.hi_byte   = held_ff;
   assign push_entry.flush     = flush;
   assign push_entry.last      = in_pkt && (pos_eff + LEN_BITS'(1) == len_eff);
   assign push_entry.clear_err = req_data.packet_start;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         len_ff   <= '0;
         seg_ff   <= '0;
         kind_ff  <= '0;
         obj_ff   <= '0;
         fo_ff    <= '0;
         held_ff  <= '0;
         crop_ff  <= 1'b0;
         phase_ff <= PH_TYPE;
      end else if (accept) begin
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         seg_ff   <= seg_in;
         kind_ff  <= kind_in;
         obj_ff   <= obj_in;
         fo_ff    <= fo_in;
         held_ff  <= held_in;
         crop_ff  <= crop_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: hdl/pscr_queue.sv
// pscr_queue: short register queue of classified transactions between front and back
// depends on pscr_pkg
module pscr_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  pscr_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output pscr_pkg::entry_type head_entry
);
   import pscr_pkg::*;

   entry_type          slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_push, do_pop;

   assign full       = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      do_push && !do_pop |=> count_ff == $past(count_ff) + QCNT_W'(1))
      else $error("queue count did not grow on push");
`endif

endmodule

FILE: hdl/pscr_back.sv
// pscr_back: carries out queued transactions, field rewrite, bound checks, result register
// depends on pscr_pkg
module pscr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  pscr_pkg::cfg_type     cfg,
   input  logic                  head_valid,
   input  pscr_pkg::entry_type   head_entry,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output pscr_pkg::rsp_data_type rsp_data
);
   import pscr_pkg::*;

   logic signed [OFS_W-1:0] off_x_ff, off_y_ff, diff_x, diff_y;
   logic signed [SUM_W-1:0] sum_x, sum_y;
   logic                    err_ff, err_in, second_ff, second_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_data_type            rsp_data_ff, rsp_data_in;
   logic [REG_W-1:0]        v, nv;
   logic                    check, two, advance, final_beat;

   assign v      = {head_entry.hi_byte, head_entry.lo_byte};
   assign diff_x = $signed({2'b0, v}) - $signed({2'b0, cfg.crop_left});
   assign diff_y = $signed({2'b0, v}) - $signed({2'b0, cfg.crop_top});
   assign sum_x  = SUM_W'(off_x_ff) + $signed({3'b0, v});
   assign sum_y  = SUM_W'(off_y_ff) + $signed({3'b0, v});

   always_comb begin
      nv    = v;
      check = 1'b0;
      case (head_entry.op)
         OP_W: begin
            nv    = cfg.output_width;
            check = v < cfg.output_width;
         end
         OP_H: begin
            nv    = cfg.output_height;
            check = v < cfg.output_height;
         end
         OP_X:    nv = diff_x[REG_W-1:0];
         OP_Y:    nv = diff_y[REG_W-1:0];
         OP_CW:   check = sum_x > $signed({3'b0, cfg.output_width});
         OP_CH:   check = sum_y > $signed({3'b0, cfg.output_height});
         default: nv = v;
      endcase
   end

   assign two        = head_entry.flush || (head_entry.op != OP_PASS);
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign final_beat = !two || second_ff;
   assign pop        = advance && head_valid && final_beat;
   assign err_in     = (head_entry.clear_err ? 1'b0 : err_ff) | check;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      second_in    = second_ff;
      if (advance) begin
         rsp_valid_in = head_valid;
         if (head_valid) begin
            if (final_beat) begin
               rsp_data_in.out_byte     = (head_entry.op == OP_PASS) ? head_entry.lo_byte
                                                                      : nv[BYTE_W-1:0];
               rsp_data_in.packet_end   = head_entry.last;
               rsp_data_in.bounds_error = head_entry.last && err_in;
               second_in                = 1'b0;
            end else begin
               rsp_data_in.out_byte     = head_entry.flush ? head_entry.hi_byte
                                                           : nv[REG_W-1:BYTE_W];
               rsp_data_in.packet_end   = 1'b0;
               rsp_data_in.bounds_error = 1'b0;
               second_in                = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
         err_ff       <= 1'b0;
         off_x_ff     <= '0;
         off_y_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
         if (pop) begin
            err_ff <= err_in;
            if (head_entry.op == OP_X) begin
               off_x_ff <= diff_x;
            end
            if (head_entry.op == OP_Y) begin
               off_y_ff <= diff_y;
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   a_err_on_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.bounds_error |-> rsp_data_ff.packet_end)
      else $error("bounds error without packet end");
   a_second_has_head: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> head_valid)
      else $error("second beat without queued transaction");
   a_first_beat_shown: assert property (@(posedge clock) disable iff (reset)
      $rose(second_ff) |-> rsp_valid_ff && !rsp_data_ff.packet_end)
      else $error("first beat not presented");
`endif

endmodule

FILE: hdl/pgs_segment_crop_rewriter.sv
// pgs_segment_crop_rewriter: top level, configuration registers and front/queue/back
// depends on pscr_pkg, pscr_front, pscr_queue, pscr_back
// throughput: one byte per cycle unless the queue is full (req_stall);
// a rewritten 16-bit field gives two results for two bytes
// a restart that flushes a held byte gives one extra result
// reset: synchronous, clears parser state, queue, result valid and registers to zero
module pgs_segment_crop_rewriter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  pscr_pkg::req_data_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output pscr_pkg::rsp_data_type        rsp_data,
   input  logic                          csr_write_enable,
   input  logic [pscr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pscr_pkg::REG_W-1:0]    csr_write_data
);
   import pscr_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   entry_type push_entry, head_entry;
   logic      accept, push, full, pop, head_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_OUTPUT_WIDTH:  cfg_in.output_width  = csr_write_data;
            CSR_OUTPUT_HEIGHT: cfg_in.output_height = csr_write_data;
            CSR_CROP_LEFT:     cfg_in.crop_left     = csr_write_data;
            CSR_CROP_TOP:      cfg_in.crop_top      = csr_write_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   pscr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req_data   (req_data),
      .push       (push),
      .push_entry (push_entry)
   );

   pscr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   pscr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: dv/pgs_segment_crop_rewriter_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for pgs_segment_crop_rewriter: PGS packets go in byte by byte and
// each rewritten byte is compared with a predictor built into a small scoreboard class.
// depends on pscr_pkg and the rewriter RTL under hdl

import pscr_pkg::*;

class crop_rewrite_model;
   cfg_type            regs;
   logic [15:0]        byte_pos, pkt_len, seg_left;
   logic [7:0]         seg_kind, obj_left, held_hi;
   phase_type          phase;
   logic [4:0]         fo;
   logic signed [17:0] ofs_x, ofs_y;
   bit                 crop_blk, err_seen;
   rsp_data_type       step_out[3];
   int                 n_out;
   rsp_data_type       expected_bytes[$];
   int                 mismatches;

   function new();
      regs = '0;
      byte_pos = '0;
      pkt_len = '0;
      seg_left = '0;
      seg_kind = '0;
      obj_left = '0;
      held_hi = '0;
      phase = PH_TYPE;
      fo = '0;
      ofs_x = '0;
      ofs_y = '0;
      crop_blk = 1'b0;
      err_seen = 1'b0;
      mismatches = 0;
   endfunction

   function void write_reg(csr_index_type idx, logic [15:0] v);
      case (idx)
         CSR_OUTPUT_WIDTH:  regs.output_width = v;
         CSR_OUTPUT_HEIGHT: regs.output_height = v;
         CSR_CROP_LEFT:     regs.crop_left = v;
         CSR_CROP_TOP:      regs.crop_top = v;
         default: ;
      endcase
   endfunction

   function int pending();
      return expected_bytes.size();
   endfunction

   function bit holding();
      case (phase)
         PH_PCS:     return fo == 5'd1 || fo == 5'd3;
         PH_PCS_OBJ: return fo >= 5'd5 && fo[0];
         PH_WDS_OBJ: return fo >= 5'd2 && !fo[0];
         default:    return 1'b0;
      endcase
   endfunction

   function void push_out(logic [7:0] v);
      step_out[n_out].out_byte = v;
      step_out[n_out].packet_end = 1'b0;
      step_out[n_out].bounds_error = 1'b0;
      n_out++;
   endfunction

   function logic [15:0] apply(op_type op, logic [15:0] v);
      case (op)
         OP_W: begin
            if (v < regs.output_width) err_seen = 1'b1;
            return regs.output_width;
         end
         OP_H: begin
            if (v < regs.output_height) err_seen = 1'b1;
            return regs.output_height;
         end
         OP_X: begin
            ofs_x = 18'(int'(v) - int'(regs.crop_left));
            return ofs_x[15:0];
         end
         OP_Y: begin
            ofs_y = 18'(int'(v) - int'(regs.crop_top));
            return ofs_y[15:0];
         end
         OP_CW: begin
            if (int'(ofs_x) + int'(v) > int'(regs.output_width)) err_seen = 1'b1;
            return v;
         end
         OP_CH: begin
            if (int'(ofs_y) + int'(v) > int'(regs.output_height)) err_seen = 1'b1;
            return v;
         end
         default: return v;
      endcase
   endfunction

   // field walk inside a segment body
   function op_type walk(logic [7:0] b, logic [15:0] rem);
      op_type op;
      op = OP_PASS;
      case (phase)
         PH_PCS: begin
            if (fo == 5'd0 || fo == 5'd2) op = (rem >= 16'd2) ? OP_HOLD : OP_PASS;
            else if (fo == 5'd1) op = OP_W;
            else if (fo == 5'd3) op = OP_H;
            if (fo == 5'd10) begin
               obj_left = b;
               phase = PH_PCS_OBJ;
               fo = '0;
            end else begin
               fo = fo + 5'd1;
            end
         end
         PH_PCS_OBJ: begin
            if (fo == 5'd0 && (obj_left == 8'd0 || rem < 16'd8)) begin
               phase = PH_SKIP;
               return OP_PASS;
            end
            if (fo == 5'd3) crop_blk = b[CROP_FLAG_BIT] && rem >= 16'd13;
            if (fo >= 5'd4 && !fo[0]) op = OP_HOLD;
            else if (fo == 5'd5 || fo == 5'd9) op = OP_X;
            else if (fo == 5'd7 || fo == 5'd11) op = OP_Y;
            else if (fo == 5'd13) op = OP_CW;
            else if (fo == 5'd15) op = OP_CH;
            if ((fo == 5'd7 && !crop_blk) || fo == 5'd15) begin
               obj_left = obj_left - 8'd1;
               fo = '0;
            end else begin
               fo = fo + 5'd1;
            end
         end
         PH_WDS_CNT: begin
            obj_left = b;
            phase = PH_WDS_OBJ;
            fo = '0;
         end
         PH_WDS_OBJ: begin
            if (fo == 5'd0 && (obj_left == 8'd0 || rem < 16'd9)) begin
               phase = PH_SKIP;
               return OP_PASS;
            end
            if (fo == 5'd1 || fo == 5'd3 || fo == 5'd5 || fo == 5'd7) op = OP_HOLD;
            else if (fo == 5'd2) op = OP_X;
            else if (fo == 5'd4) op = OP_Y;
            else if (fo == 5'd6) op = OP_CW;
            else if (fo == 5'd8) op = OP_CH;
            if (fo == 5'd8) begin
               obj_left = obj_left - 8'd1;
               fo = '0;
            end else begin
               fo = fo + 5'd1;
            end
         end
         default: ;
      endcase
      return op;
   endfunction

   function void note_byte(req_data_type t);
      logic [15:0] len, size, nv;
      logic [7:0]  b;
      int          pos;
      op_type      op;
      b = t.data_byte;
      op = OP_PASS;
      n_out = 0;
      if (t.packet_start) begin
         // an aborted packet gives back its held high byte untouched
         if (byte_pos < pkt_len && holding()) push_out(held_hi);
         len = (t.packet_length == '0) ? 16'd1 : t.packet_length;
         pkt_len = len;
         byte_pos = '0;
         seg_left = '0;
         seg_kind = '0;
         phase = PH_TYPE;
         obj_left = '0;
         fo = '0;
         crop_blk = 1'b0;
         err_seen = 1'b0;
      end
      if (byte_pos >= pkt_len) begin
         push_out(b);
      end else begin
         pos = int'(byte_pos);
         case (phase)
            PH_TYPE: begin
               if (pos + 3 > int'(pkt_len)) begin
                  phase = PH_TAIL;
               end else begin
                  seg_kind = b;
                  phase = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               held_hi = b;
               phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               size = {held_hi, b};
               if (pos + 1 + int'(size) > int'(pkt_len)) begin
                  phase = PH_TAIL;
               end else begin
                  seg_left = size;
                  fo = '0;
                  if (size == '0) phase = PH_TYPE;
                  else if (seg_kind == SEG_PCS) phase = PH_PCS;
                  else if (seg_kind == SEG_WDS) phase = PH_WDS_CNT;
                  else phase = PH_SKIP;
               end
            end
            PH_TAIL: ;
            default: begin
               op = walk(b, seg_left);
               seg_left = seg_left - 16'd1;
               if (seg_left == '0) begin
                  phase = PH_TYPE;
                  fo = '0;
               end
            end
         endcase
         if (op == OP_HOLD) begin
            held_hi = b;
         end else if (op == OP_PASS) begin
            push_out(b);
         end else begin
            nv = apply(op, {held_hi, b});
            push_out(nv[15:8]);
            push_out(nv[7:0]);
         end
         byte_pos = 16'(pos + 1);
         if (byte_pos >= pkt_len && n_out > 0) begin
            step_out[n_out-1].packet_end = 1'b1;
            step_out[n_out-1].bounds_error = err_seen;
         end
      end
      for (int i = 0; i < n_out; i++) expected_bytes.push_back(step_out[i]);
   endfunction

   function void check_byte(rsp_data_type got);
      rsp_data_type want;
      if (expected_bytes.size() == 0) begin
         $error("unexpected transaction: out_byte %02h packet_end %0b bounds_error %0b",
                got.out_byte, got.packet_end, got.bounds_error);
         mismatches++;
         return;
      end
      want = expected_bytes.pop_front();
      if (got.out_byte !== want.out_byte) begin
         $error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
         mismatches++;
      end
      if (got.packet_end !== want.packet_end) begin
         $error("packet_end: expected %0b, actual %0b", want.packet_end, got.packet_end);
         mismatches++;
      end
      if (got.bounds_error !== want.bounds_error) begin
         $error("bounds_error: expected %0b, actual %0b", want.bounds_error, got.bounds_error);
         mismatches++;
      end
   endfunction
endclass

module pgs_segment_crop_rewriter_test;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RESET_CYCLES  = 6;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int PHASES        = 8;
   localparam int PHASE_BYTES   = 150;
   localparam int CYCLE_LIMIT   = 200000;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_data_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_data_type           rsp_data;
   logic                   csr_write_enable;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [REG_W-1:0]       csr_write_data;

   crop_rewrite_model rewriter = new();
   cfg_type           cfg_now;
   logic [7:0]        body_bytes[$];
   logic [7:0]        packet_bytes[$];
   bit                sender_idles;
   bit                receiver_idles;
   bit                long_hold_pending;
   int                bytes_sent;
   int                cycle_count;

   pgs_segment_crop_rewriter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // result side: random stall per transaction, plus one long hold-off on request
   initial begin : receiver
      int wait_cycles;
      rsp_stall = 1'b0;
      wait_cycles = 0;
      forever begin
         @(negedge clock);
         if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            wait_cycles = LONG_HOLD;
         end
         rsp_stall <= (wait_cycles > 0);
         if (wait_cycles > 0) wait_cycles--;
         @(posedge clock);
         if (rsp_valid === 1'b1 && !rsp_stall) begin
            rewriter.check_byte(rsp_data);
            wait_cycles = receiver_idles ? $urandom_range(0, 3) : 0;
         end
      end
   end

   function automatic req_data_type make_item(logic [7:0] b, bit start, logic [15:0] len);
      req_data_type t;
      t.data_byte = b;
      t.packet_start = start;
      t.packet_length = start ? len : 16'($urandom);
      return t;
   endfunction

   // entered and left at a falling edge; valid stays high into the next call
   task automatic send_byte(input req_data_type t);
      int gap;
      gap = sender_idles ? $urandom_range(0, 3) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      rewriter.note_byte(t);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (rewriter.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [15:0] v);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= v;
      @(negedge clock);
      rewriter.write_reg(idx, v);
   endtask

   task automatic set_registers(input logic [15:0] w, input logic [15:0] h,
                                input logic [15:0] l, input logic [15:0] t);
      write_register(CSR_OUTPUT_WIDTH, w);
      write_register(CSR_OUTPUT_HEIGHT, h);
      write_register(CSR_CROP_LEFT, l);
      write_register(CSR_CROP_TOP, t);
      csr_write_enable <= 1'b0;
      cfg_now = '{output_width: w, output_height: h, crop_left: l, crop_top: t};
   endtask

   function automatic void put_word(logic [15:0] v);
      body_bytes.push_back(v[15:8]);
      body_bytes.push_back(v[7:0]);
   endfunction

   function automatic logic [15:0] pick_size(logic [15:0] target);
      case ($urandom_range(0, 4))
         0:       return 16'($urandom);
         1:       return target;
         2:       return target - 16'($urandom_range(1, 4));
         default: return target + 16'($urandom_range(0, 64));
      endcase
   endfunction

   function automatic logic [15:0] pick_pos(logic [15:0] crop, logic [15:0] span);
      if ($urandom_range(0, 4) == 0) return 16'($urandom);
      return crop + 16'($urandom_range(0, int'(span)));
   endfunction

   function automatic logic [15:0] pick_extent(logic [15:0] span);
      case ($urandom_range(0, 4))
         0:       return 16'($urandom);
         1:       return span;
         default: return 16'($urandom_range(0, int'(span)));
      endcase
   endfunction

   function automatic void build_composition();
      int         objects;
      logic [7:0] flags;
      body_bytes.delete();
      put_word(pick_size(cfg_now.output_width));
      put_word(pick_size(cfg_now.output_height));
      // frame rate, composition number, state, palette update, palette id
      repeat (6) body_bytes.push_back(8'($urandom));
      objects = $urandom_range(0, 3);
      body_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(objects));
      for (int i = 0; i < objects; i++) begin
         put_word(16'($urandom));
         body_bytes.push_back(8'($urandom));
         flags = 8'($urandom);
         body_bytes.push_back(flags);
         put_word(pick_pos(cfg_now.crop_left, cfg_now.output_width));
         put_word(pick_pos(cfg_now.crop_top, cfg_now.output_height));
         if (flags[CROP_FLAG_BIT]) begin
            put_word(pick_pos(cfg_now.crop_left, cfg_now.output_width));
            put_word(pick_pos(cfg_now.crop_top, cfg_now.output_height));
            put_word(pick_extent(cfg_now.output_width));
            put_word(pick_extent(cfg_now.output_height));
         end
      end
   endfunction

   function automatic void build_windows();
      int objects;
      body_bytes.delete();
      objects = $urandom_range(0, 3);
      body_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(objects));
      for (int i = 0; i < objects; i++) begin
         body_bytes.push_back(8'($urandom));
         put_word(pick_pos(cfg_now.crop_left, cfg_now.output_width));
         put_word(pick_pos(cfg_now.crop_top, cfg_now.output_height));
         put_word(pick_extent(cfg_now.output_width));
         put_word(pick_extent(cfg_now.output_height));
      end
   endfunction

   // header plus body; a mangled length gives empty, cut-short or overrunning segments
   function automatic void close_segment(logic [7:0] kind, bit mangle);
      int size;
      size = body_bytes.size();
      if (mangle) begin
         case ($urandom_range(0, 19))
            0:       size = 0;
            1:       size = $urandom_range(0, size);
            2:       size = size + $urandom_range(1, 40);
            default: ;
         endcase
      end
      packet_bytes.push_back(kind);
      packet_bytes.push_back(8'(size >> 8));
      packet_bytes.push_back(8'(size));
      foreach (body_bytes[i]) packet_bytes.push_back(body_bytes[i]);
   endfunction

   function automatic void build_packet();
      logic [7:0] kind;
      packet_bytes.delete();
      repeat ($urandom_range(1, 3)) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               build_composition();
               close_segment(SEG_PCS, 1'b1);
            end
            4, 5, 6, 7: begin
               build_windows();
               close_segment(SEG_WDS, 1'b1);
            end
            default: begin
               kind = 8'($urandom);
               if (kind == SEG_PCS || kind == SEG_WDS) kind = 8'h80;
               body_bytes.delete();
               repeat ($urandom_range(0, 6)) body_bytes.push_back(8'($urandom));
               close_segment(kind, 1'b1);
            end
         endcase
      end
      if ($urandom_range(0, 7) == 0)
         repeat ($urandom_range(1, 2)) packet_bytes.push_back(8'($urandom));
   endfunction

   task automatic send_packet(input int len, input int cut);
      for (int i = 0; i < cut; i++)
         send_byte(make_item(packet_bytes[i], i == 0, 16'(len)));
   endtask

   task automatic send_random_packet();
      int len, cut;
      build_packet();
      len = packet_bytes.size();
      cut = len;
      case ($urandom_range(0, 19))
         0:       len = len - $urandom_range(1, len);
         1:       len = $urandom_range(len + 1, 65535);
         2:       cut = $urandom_range(1, len);
         default: ;
      endcase
      send_packet(len, cut);
   endtask

   task automatic run_directed();
      // stray bytes with no packet open
      send_byte(make_item(8'h00, 1'b0, 16'hFFFF));
      send_byte(make_item(8'hFF, 1'b0, 16'h0000));
      // zero length counts as one byte
      send_byte(make_item(SEG_PCS, 1'b1, 16'h0000));
      // composition with a cropped object at the extremes, a window, an unknown segment
      // and a short tail
      packet_bytes.delete();
      body_bytes.delete();
      put_word(16'hFFFF);
      put_word(16'h0000);
      repeat (6) body_bytes.push_back(8'h00);
      body_bytes.push_back(8'd1);
      put_word(16'h0000);
      body_bytes.push_back(8'h00);
      body_bytes.push_back(8'hFF);
      put_word(16'h0000);
      put_word(16'hFFFF);
      put_word(cfg_now.crop_left);
      put_word(cfg_now.crop_top);
      put_word(cfg_now.output_width);
      put_word(cfg_now.output_height);
      close_segment(SEG_PCS, 1'b0);
      body_bytes.delete();
      body_bytes.push_back(8'd1);
      body_bytes.push_back(8'h00);
      put_word(16'hFFFF);
      put_word(16'h0000);
      put_word(16'hFFFF);
      put_word(16'h0000);
      close_segment(SEG_WDS, 1'b0);
      body_bytes.delete();
      put_word(16'h1234);
      close_segment(8'h80, 1'b0);
      packet_bytes.push_back(8'h16);
      packet_bytes.push_back(8'h00);
      send_packet(packet_bytes.size(), packet_bytes.size());
      // segment body running past the packet end
      packet_bytes = '{SEG_WDS, 8'h00, 8'hFF, 8'h01, 8'h02, 8'h03};
      send_packet(6, 6);
      // restart while the width high byte is held
      packet_bytes = '{SEG_PCS, 8'h00, 8'd11, 8'h07};
      send_packet(14, 4);
      // in-bounds composition with a cropped object, no error expected
      packet_bytes.delete();
      body_bytes.delete();
      put_word(cfg_now.output_width);
      put_word(cfg_now.output_height);
      repeat (6) body_bytes.push_back(8'h00);
      body_bytes.push_back(8'd1);
      put_word(16'h0001);
      body_bytes.push_back(8'h00);
      body_bytes.push_back(8'h80);
      put_word(cfg_now.crop_left);
      put_word(cfg_now.crop_top);
      put_word(cfg_now.crop_left);
      put_word(cfg_now.crop_top);
      put_word(16'd4);
      put_word(16'd4);
      close_segment(SEG_PCS, 1'b0);
      send_packet(packet_bytes.size(), packet_bytes.size());
   endtask

   initial begin : stimulus
      int target;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      cycle_count = 0;
      bytes_sent = 0;
      long_hold_pending = 1'b0;
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      cfg_now = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_registers(16'd1920, 16'd1080, 16'd16, 16'd8);
      run_directed();

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         case (phase)
            0:       set_registers(16'h0000, 16'h0000, 16'h0000, 16'h0000);
            1:       set_registers(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            2:       set_registers(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
            3:       set_registers(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
            default: set_registers(16'($urandom_range(64, 4096)), 16'($urandom_range(64, 2160)),
                                   16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)));
         endcase
         sender_idles = (phase % 4 == 0) || (phase % 4 == 2);
         receiver_idles = (phase % 4 == 0) || (phase % 4 == 3);
         // result side holds off while packets keep coming
         if (phase == 2) long_hold_pending = 1'b1;
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) begin
            send_random_packet();
            if (phase == 5 && bytes_sent >= target - PHASE_BYTES / 2 && rewriter.pending() > 0)
               drain();
         end
      end

      drain();
      if (rewriter.mismatches == 0 && rewriter.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/pscr_pkg.sv
hdl/pscr_front.sv
hdl/pscr_queue.sv
hdl/pscr_back.sv
hdl/pgs_segment_crop_rewriter.sv
dv/pgs_segment_crop_rewriter_test.sv
